// ===== hdl/dssm_pkg.sv =====
// ----------------------------------------------------------------------------
// dssm_pkg: shared definitions for the dual stack shared memory core
// Widths, register defaults, command codes and the types that pass from the
// front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int CAP_W         = 11;
  localparam int CMD_W         = 2;
  localparam int DATA_W        = 32;
  localparam int CAP_RESET     = 10;
  localparam int QUEUE_DEPTH   = 2;

  // Command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // Operation class after decode; the unused code becomes a no-op
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queued command
  typedef struct packed {
    op_t                       op;
    logic                      sel;
    logic signed [DATA_W-1:0]  value;
  } q_entry_t;

endpackage

// ===== hdl/dssm_if.sv =====
// ----------------------------------------------------------------------------
// dssm_if: request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface dssm_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [dssm_pkg::CMD_W-1:0]            command;
  logic                                  stack_select;
  logic signed [dssm_pkg::DATA_W-1:0]    push_value;

  modport source (output valid, command, stack_select, push_value, input ready);
  modport sink   (input valid, command, stack_select, push_value, output ready);
endinterface

interface dssm_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dssm_pkg::DATA_W-1:0]    read_value;
  logic [1:0]                            status;
  logic                                  low_empty;
  logic                                  high_empty;

  modport source (output valid, read_value, status, low_empty, high_empty, input ready);
  modport sink   (input valid, read_value, status, low_empty, high_empty, output ready);
endinterface

// ===== hdl/dssm_front.sv =====
// ----------------------------------------------------------------------------
// dssm_front: request intake and command queue
// Decode each request into an operation class and hold it in a short queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module dssm_front (
  input  logic                clk,
  input  logic                rst,
  dssm_req_if.sink            req,
  output logic                q_valid,
  input  logic                q_ready,
  output dssm_pkg::q_entry_t  q_entry
);

  localparam int PW = $clog2(dssm_pkg::QUEUE_DEPTH);

  dssm_pkg::q_entry_t  ent [dssm_pkg::QUEUE_DEPTH];
  dssm_pkg::q_entry_t  dec;
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;
  logic                push;
  logic                pop;

  always_comb begin
    dec.sel   = req.stack_select;
    dec.value = req.push_value;
    unique case (req.command)
      dssm_pkg::CMD_PUSH: dec.op = dssm_pkg::OP_PUSH;
      dssm_pkg::CMD_POP:  dec.op = dssm_pkg::OP_POP;
      dssm_pkg::CMD_PEEK: dec.op = dssm_pkg::OP_PEEK;
      default:            dec.op = dssm_pkg::OP_NOP;
    endcase
  end

  assign req.ready = (count != (PW+1)'(dssm_pkg::QUEUE_DEPTH));
  assign q_valid   = (count != '0);
  assign q_entry   = ent[rd_ptr];
  assign push      = req.valid && req.ready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dssm_back.sv =====
// ----------------------------------------------------------------------------
// dssm_back: stack execution unit
// Hold the capacity register and both stack counts, access the shared store
// and present one response per command through a pending and output stage.
// ----------------------------------------------------------------------------
module dssm_back #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dssm_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  dssm_pkg::q_entry_t             q_entry,
  dssm_rsp_if.source                     rsp
);

  localparam int CW = dssm_pkg::CAP_W;
  localparam int DW = dssm_pkg::DATA_W;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > CW) ? AW : CW;
  localparam logic [CW-1:0] CAP_RST = (dssm_pkg::CAP_RESET > DEPTH) ?
                                      CW'(DEPTH) : CW'(dssm_pkg::CAP_RESET);

  logic [DW-1:0]        mem [DEPTH];
  logic [DW-1:0]        rd_data;

  logic [CW-1:0]        cap;
  logic [CW-1:0]        low_cnt;
  logic [CW-1:0]        high_cnt;
  logic [CW-1:0]        low_cnt_next;
  logic [CW-1:0]        high_cnt_next;
  logic [CW-1:0]        cap_next;

  logic [CW-1:0]        cnt;
  logic [CW:0]          used;
  logic                 full;
  logic [CW-1:0]        idx;
  logic [IW-1:0]        idx_ext;
  logic [AW-1:0]        addr;
  logic                 we;
  logic                 re;
  logic                 neg_one;
  dssm_pkg::status_t    st;
  logic                 fire;

  logic                 pend_valid;
  logic                 pend_use_mem;
  logic                 pend_neg_one;
  dssm_pkg::status_t    pend_status;
  logic                 pend_low_empty;
  logic                 pend_high_empty;
  logic                 pend_take;

  logic                 out_valid;
  logic [DW-1:0]        out_value;
  dssm_pkg::status_t    out_status;
  logic                 out_low_empty;
  logic                 out_high_empty;

  // Saturate the written capacity to the store size
  always_comb begin
    if (32'(cfg_wdata) > 32'(DEPTH)) begin
      cap_next = CW'(DEPTH);
    end else begin
      cap_next = cfg_wdata;
    end
  end

  always_comb begin
    cnt  = q_entry.sel ? high_cnt : low_cnt;
    used = {1'b0, low_cnt} + {1'b0, high_cnt};
    full = (used >= {1'b0, cap});

    low_cnt_next  = low_cnt;
    high_cnt_next = high_cnt;
    we            = 1'b0;
    re            = 1'b0;
    neg_one       = 1'b0;
    st            = dssm_pkg::ST_OK;
    idx           = q_entry.sel ? (cap - cnt) : (cnt - 1'b1);

    unique case (q_entry.op)
      dssm_pkg::OP_PUSH: begin
        idx = q_entry.sel ? (cap - 1'b1 - high_cnt) : low_cnt;
        if (full) begin
          st = dssm_pkg::ST_FULL;
        end else begin
          we = 1'b1;
          if (q_entry.sel) begin
            high_cnt_next = high_cnt + 1'b1;
          end else begin
            low_cnt_next = low_cnt + 1'b1;
          end
        end
      end
      dssm_pkg::OP_POP: begin
        if (cnt == '0) begin
          st      = dssm_pkg::ST_EMPTY;
          neg_one = 1'b1;
        end else begin
          re = 1'b1;
          if (q_entry.sel) begin
            high_cnt_next = high_cnt - 1'b1;
          end else begin
            low_cnt_next = low_cnt - 1'b1;
          end
        end
      end
      dssm_pkg::OP_PEEK: begin
        if (cnt == '0) begin
          st = dssm_pkg::ST_EMPTY;
        end else begin
          re = 1'b1;
        end
      end
      dssm_pkg::OP_NOP: begin
        st = dssm_pkg::ST_OK;
      end
      default: begin
        st = dssm_pkg::ST_OK;
      end
    endcase

    idx_ext = IW'(idx);
    addr    = idx_ext[AW-1:0];
  end

  assign pend_take = pend_valid && (!out_valid || rsp.ready);
  assign q_ready   = !pend_valid || pend_take;
  assign fire      = q_valid && q_ready;

  // Shared store: one write or one registered read per command
  always_ff @(posedge clk) begin
    if (fire && we) begin
      mem[addr] <= q_entry.value;
    end
    if (fire && re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= CAP_RST;
      low_cnt  <= '0;
      high_cnt <= '0;
    end else if (cfg_we) begin
      cap      <= cap_next;
      low_cnt  <= '0;
      high_cnt <= '0;
    end else if (fire) begin
      low_cnt  <= low_cnt_next;
      high_cnt <= high_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (fire) begin
      pend_valid <= 1'b1;
    end else if (pend_take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_use_mem    <= re;
      pend_neg_one    <= neg_one;
      pend_status     <= st;
      pend_low_empty  <= (low_cnt_next == '0);
      pend_high_empty <= (high_cnt_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      if (pend_use_mem) begin
        out_value <= rd_data;
      end else if (pend_neg_one) begin
        out_value <= '1;
      end else begin
        out_value <= '0;
      end
      out_status     <= pend_status;
      out_low_empty  <= pend_low_empty;
      out_high_empty <= pend_high_empty;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.low_empty  = out_low_empty;
  assign rsp.high_empty = out_high_empty;

endmodule

// ===== hdl/dual_stack_shared_memory_core.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core: two stacks in one shared store
// Push, pop and peek on a low stack growing upward and a high stack growing
// downward, both inside the first capacity entries of one memory.
// ----------------------------------------------------------------------------
// Two LIFO stacks share the first `capacity` entries of a DEPTH-entry store:
// the low stack fills from entry 0 upward, the high stack from entry
// capacity-1 downward. Each request names a stack and a command (push, pop,
// peek; the unused code does nothing) and yields exactly one response with
// the read data, a status (ok, full on a refused push, empty on a pop or
// peek of an empty stack) and the empty flag of each stack after the
// command. An empty pop reads -1, every other non-read response reads 0.
// Throughput is one request per clock while the response side keeps up:
// the back end executes one command per cycle with one store access and one
// count update, and a read sees a write made by the command just before it.
// A response passes from the command queue through the pending stage, which
// takes the registered store read, to the output register, and a two-deep
// queue plus a pending stage keep the request side moving while the response
// side stalls. Writing capacity (saturated to DEPTH) empties both stacks;
// write it only while no request is in flight. Store contents need no
// clearing after reset, since only pushed entries are ever read.
module dual_stack_shared_memory_core #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dssm_pkg::CAP_W-1:0]  cfg_wdata,
  dssm_req_if.sink                    req,
  dssm_rsp_if.source                  rsp
);

  // Queue handshake between front end and back end
  logic                q_valid;
  logic                q_ready;
  dssm_pkg::q_entry_t  q_entry;

  // Accept and classify requests, buffer them
  dssm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  // Execute commands against the counts and the shared store
  dssm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .rsp       (rsp)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for dual_stack_shared_memory_core
// Drives push, pop, peek and no-op requests at a low and a high stack that
// share one store, under several capacities, and checks every response
// against a stack tracker kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import dssm_pkg::*;

  // The package names no code for the unused command; it must act as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int RANDOM_ITEMS  = 118;      // per phase with a nonzero capacity
  localparam int ZERO_CAP_ITEMS = 30;      // zero capacity: pushes full, pops and peeks empty

  // One expected response
  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic                     low_empty;
    logic                     high_empty;
  } stack_reply_t;

  // Response ready patterns, each held for a random segment
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_TOGGLE
  } rx_pattern_t;

  // --------------------------------------------------------------------------
  // Stack tracker: its own copy of the store, both counts and the capacity.
  // note_request works out the response of each accepted request and queues
  // it; check_reply compares each accepted response with the oldest one.
  // --------------------------------------------------------------------------
  class stack_tracker;
    logic [DATA_W-1:0] store [DEPTH_DEFAULT];
    int unsigned       cap      = CAP_RESET;
    int unsigned       low_cnt  = 0;
    int unsigned       high_cnt = 0;
    stack_reply_t      pending_replies [$];
    int unsigned       mismatches = 0;

    // Writing capacity saturates at the store depth and empties both stacks
    function void set_capacity(logic [CAP_W-1:0] v);
      cap      = (v > DEPTH_DEFAULT) ? DEPTH_DEFAULT : v;
      low_cnt  = 0;
      high_cnt = 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic sel, logic [DATA_W-1:0] val);
      stack_reply_t rep;
      int unsigned  cnt;
      int unsigned  top_idx;
      int unsigned  slot;
      cnt     = sel ? high_cnt : low_cnt;
      top_idx = 0;
      // Low element i sits at entry i, high element j at entry cap-1-j
      if (cnt != 0)
        top_idx = sel ? cap - cnt : cnt - 1;
      rep.read_value = '0;
      rep.status     = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (low_cnt + high_cnt >= cap) begin
            rep.status = ST_FULL;
          end else begin
            slot = sel ? cap - 1 - high_cnt : low_cnt;
            store[slot] = val;
            if (sel) high_cnt++;
            else     low_cnt++;
          end
        end
        CMD_POP: begin
          if (cnt == 0) begin
            rep.read_value = '1;
            rep.status     = ST_EMPTY;
          end else begin
            rep.read_value = store[top_idx];
            if (sel) high_cnt--;
            else     low_cnt--;
          end
        end
        CMD_PEEK: begin
          if (cnt == 0) rep.status = ST_EMPTY;
          else          rep.read_value = store[top_idx];
        end
        default: begin
        end
      endcase
      rep.low_empty  = (low_cnt == 0);
      rep.high_empty = (high_cnt == 0);
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(stack_reply_t got);
      stack_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("response with no request outstanding: read_value %0d status %0d",
               got.read_value, got.status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.low_empty !== want.low_empty) begin
        $error("low_empty: expected %0b, got %0b", want.low_empty, got.low_empty);
        mismatches++;
      end
      if (got.high_empty !== want.high_empty) begin
        $error("high_empty: expected %0b, got %0b", want.high_empty, got.high_empty);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  dssm_req_if req_ch ();
  dssm_rsp_if rsp_ch ();

  dual_stack_shared_memory_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #2 clk = ~clk;

  stack_tracker tracker = new();

  // Long response hold-off, requested by the stimulus and timed by the pacer
  bit          rsp_hold_req    = 1'b0;
  int unsigned rsp_hold_cycles = 0;

  int unsigned cycle_count = 0;

  // Every input known from time zero
  initial begin
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_PUSH;
    req_ch.stack_select = 1'b0;
    req_ch.push_value   = '0;
    rsp_ch.ready        = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. A request is noted
  // before a response is checked, though the two can never refer to each
  // other in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stack_reply_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        tracker.note_request(req_ch.command, req_ch.stack_select, req_ch.push_value);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.read_value = rsp_ch.read_value;
        got.status     = status_t'(rsp_ch.status);
        got.low_empty  = rsp_ch.low_empty;
        got.high_empty = rsp_ch.high_empty;
        tracker.check_reply(got);
      end
    end
  end

  // Cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response pacer: pick a ready pattern for a random segment, over and over.
  // A requested hold-off drops ready for a long count so that the block's
  // queue fills and it stalls the request side.
  // --------------------------------------------------------------------------
  initial begin : response_pacer
    rx_pattern_t mode;
    int unsigned seg_len;
    wait (!rst);
    forever begin
      mode    = rx_pattern_t'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 60);
      repeat (seg_len) begin
        @(negedge clk);
        if (rsp_hold_req) begin
          rsp_ch.ready = 1'b0;
          repeat (rsp_hold_cycles) @(negedge clk);
          rsp_hold_req = 1'b0;
        end
        case (mode)
          RX_ALWAYS: rsp_ch.ready = 1'b1;
          RX_RANDOM: rsp_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ch.ready = ($urandom_range(0, 3) == 0);
          default:   rsp_ch.ready = ~rsp_ch.ready;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Offer one request at the falling edge and hold it until accepted
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic sel,
                              input logic [DATA_W-1:0] val);
    @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.command      = cmd;
    req_ch.stack_select = sel;
    req_ch.push_value   = val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid for a pause as long as the argument asks; the payload wanders meanwhile
  task automatic pause_requests(input int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_W'($urandom_range(0, 3));
    req_ch.stack_select = 1'($urandom_range(0, 1));
    req_ch.push_value   = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Wait until every response is in, then let the pipeline settle
  task automatic drain_responses();
    pause_requests(1);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write capacity with the block idle; the tracker follows once the write is taken
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain_responses();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CAP_W'($urandom);
    tracker.set_capacity(v);
  endtask

  // Push values: mostly random, sometimes the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Filling runs lean on push, draining runs on pop; a few no-ops ride along
  function automatic logic [CMD_W-1:0] pick_command(input bit filling);
    int unsigned r = $urandom_range(0, 99);
    if (r < 5)  return CMD_UNUSED;
    if (r < 17) return CMD_PEEK;
    if (filling) return (r < 75) ? CMD_PUSH : CMD_POP;
    return (r < 40) ? CMD_PUSH : CMD_POP;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_caps [13] = '{1, 0, 2047, 3, 1024, 2, 24, 1500, 5, 8, 300, 16, 64};
    int unsigned items;
    int unsigned sent;
    int unsigned burst;
    int unsigned run_left;
    bit          filling;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty pop and peek on both stacks, then no-ops
    send_request(CMD_POP,    1'b0, 32'h1234_5678);
    send_request(CMD_POP,    1'b1, 32'h0);
    send_request(CMD_PEEK,   1'b0, 32'h0);
    send_request(CMD_PEEK,   1'b1, 32'hffff_ffff);
    send_request(CMD_UNUSED, 1'b0, 32'h0);
    send_request(CMD_UNUSED, 1'b1, 32'hdead_beef);
    // Extreme values on both stacks under the reset capacity
    send_request(CMD_PUSH,   1'b0, 32'h7fff_ffff);
    send_request(CMD_PUSH,   1'b1, 32'h8000_0000);
    send_request(CMD_PEEK,   1'b0, 32'h0);
    send_request(CMD_PEEK,   1'b1, 32'h0);

    // Capacity two: stacks meet, refused pushes, pop of a pushed -1
    write_capacity(11'd2);
    send_request(CMD_PUSH,   1'b0, 32'hffff_ffff);
    send_request(CMD_PUSH,   1'b1, 32'h0000_0000);
    send_request(CMD_PUSH,   1'b0, 32'h0000_0005);
    send_request(CMD_PUSH,   1'b1, 32'h0000_0006);
    send_request(CMD_POP,    1'b1, 32'h0);
    send_request(CMD_POP,    1'b0, 32'h0);
    send_request(CMD_POP,    1'b0, 32'h0);

    // Capacity zero: every push is full, both stacks stay empty
    write_capacity(11'd0);
    send_request(CMD_PUSH,   1'b0, 32'h0000_0001);
    send_request(CMD_PUSH,   1'b1, 32'h0000_0002);
    send_request(CMD_POP,    1'b0, 32'h0);
    send_request(CMD_PEEK,   1'b1, 32'h0);

    // Capacity above the depth saturates; the high stack starts at the top
    write_capacity(11'd2047);
    send_request(CMD_PUSH,   1'b1, 32'ha5a5_a5a5);
    send_request(CMD_PEEK,   1'b1, 32'h0);
    send_request(CMD_POP,    1'b1, 32'h0);

    // Random phases, one capacity each
    phase_caps[6] = $urandom_range(1, 64);
    foreach (phase_caps[p]) begin
      write_capacity(CAP_W'(phase_caps[p]));
      // Twice, hold the response side off while requests keep coming
      if (p == 3 || p == 9) begin
        rsp_hold_cycles = $urandom_range(150, 300);
        rsp_hold_req    = 1'b1;
      end
      items    = (phase_caps[p] == 0) ? ZERO_CAP_ITEMS : RANDOM_ITEMS;
      sent     = 0;
      filling  = 1'b1;
      run_left = $urandom_range(4, 40);
      while (sent < items) begin
        burst = $urandom_range(1, 40);
        while (burst != 0 && sent < items) begin
          if (run_left == 0) begin
            filling  = ~filling;
            run_left = $urandom_range(4, 40);
          end
          send_request(pick_command(filling), 1'($urandom_range(0, 1)), pick_value());
          run_left--;
          burst--;
          sent++;
        end
        // Some bursts run straight into the next one
        if ($urandom_range(0, 3) != 0)
          pause_requests($urandom_range(1, 6));
      end
    end

    // Wind down: every response in, then a few quiet cycles
    drain_responses();
    if (tracker.pending_replies.size() != 0) begin
      $error("%0d responses never arrived", tracker.pending_replies.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dssm_pkg.sv
hdl/dssm_if.sv
hdl/dssm_front.sv
hdl/dssm_back.sv
hdl/dual_stack_shared_memory_core.sv
tb/tb_top.sv
